// ----- rtl/core/otg_pkg.sv -----
`default_nettype none

package otg_pkg;

  localparam int TEMP_W        = 8;
  localparam int TICK_W        = 32;
  localparam int EVENT_W       = 16;
  localparam int CNT_W         = 4;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 32;
  localparam int FILTER_LIMIT_DEF = 10;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [TICK_W-1:0]        tick_t;
  typedef logic [EVENT_W-1:0]       event_cnt_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIP_TEMP    = 2'd0,
    REG_RELEASE_TEMP = 2'd1,
    REG_COOL_WAIT    = 2'd2
  } reg_idx_t;

  localparam temp_t TRIP_TEMP_RST    = 8'sd60;
  localparam temp_t RELEASE_TEMP_RST = 8'sd45;
  localparam tick_t COOL_WAIT_RST    = 32'd30000;

  typedef struct packed {
    temp_t trip_temp;
    temp_t release_temp;
    tick_t cool_wait;
  } otg_cfg_t;

  typedef struct packed {
    logic       charge_enable;
    logic       shutdown_request;
    logic       overheated;
    event_cnt_t overheat_events;
  } otg_result_t;

endpackage

`default_nettype wire

// ----- rtl/core/otg_cfg_regs.sv -----
`default_nettype none

module otg_cfg_regs (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire otg_pkg::cfg_idx_t wr_idx,
  input  wire otg_pkg::cfg_data_t wr_data,
  output otg_pkg::otg_cfg_t     cfg
);
  import otg_pkg::*;

  otg_cfg_t cfg_r;
  otg_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx_t'(wr_idx))
        REG_TRIP_TEMP:    cfg_nxt.trip_temp    = temp_t'(wr_data[TEMP_W-1:0]);
        REG_RELEASE_TEMP: cfg_nxt.release_temp = temp_t'(wr_data[TEMP_W-1:0]);
        REG_COOL_WAIT:    cfg_nxt.cool_wait    = wr_data[TICK_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.trip_temp    <= TRIP_TEMP_RST;
      cfg_r.release_temp <= RELEASE_TEMP_RST;
      cfg_r.cool_wait    <= COOL_WAIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- rtl/core/otg_state.sv -----
`default_nettype none

module otg_state #(
  parameter int FILTER_LIMIT = otg_pkg::FILTER_LIMIT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step_en,
  input  wire otg_pkg::temp_t     temperature,
  input  wire otg_pkg::tick_t     now_tick,
  input  wire otg_pkg::otg_cfg_t  cfg,
  output otg_pkg::otg_result_t    result
);
  import otg_pkg::*;

  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(FILTER_LIMIT);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             latched_r, latched_nxt;
  tick_t            start_r, start_nxt;
  event_cnt_t       events_r, events_nxt;
  logic             charge_r, charge_nxt;

  temp_t            thr;
  logic             hot;
  tick_t            elapsed;
  logic             shutdown;

  always_comb begin
    thr        = latched_r ? cfg.release_temp : cfg.trip_temp;
    hot        = temperature > thr;
    cnt_nxt    = cnt_r;
    latched_nxt = latched_r;
    start_nxt  = start_r;
    events_nxt = events_r;
    charge_nxt = charge_r;
    shutdown   = 1'b0;
    elapsed    = now_tick - start_r;

    if (hot) begin
      if (cnt_r < LIMIT) cnt_nxt = cnt_r + 1'b1;
    end else begin
      if (cnt_r != '0) cnt_nxt = cnt_r - 1'b1;
    end

    if (cnt_nxt == LIMIT && !latched_r) begin
      if (events_r != '1) events_nxt = events_r + 1'b1;
      start_nxt   = now_tick;
      latched_nxt = 1'b1;
      charge_nxt  = 1'b0;
    end else if (cnt_nxt == LIMIT) begin
      shutdown = elapsed > cfg.cool_wait;
    end else if (cnt_nxt == '0) begin
      charge_nxt  = 1'b1;
      latched_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      latched_r <= 1'b0;
      start_r   <= '0;
      events_r  <= '0;
      charge_r  <= 1'b1;
    end else if (step_en) begin
      cnt_r     <= cnt_nxt;
      latched_r <= latched_nxt;
      start_r   <= start_nxt;
      events_r  <= events_nxt;
      charge_r  <= charge_nxt;
    end
  end

  assign result.charge_enable    = charge_nxt;
  assign result.shutdown_request = shutdown;
  assign result.overheated       = latched_nxt;
  assign result.overheat_events  = events_nxt;

endmodule

`default_nettype wire

// ----- rtl/core/over_temperature_guard_core.sv -----
// A word taken goes to the input register, then its result to the output register.
// One word per cycle if out_stall is low; debounce state updates in a single pass.
// While a finished result waits on out_stall, the input register takes one more word,
// then in_stall rises until out_stall drops.
// Reset (rst_n low, synchronous): pipeline empty, counter and events cleared,
// charging enabled, thresholds 60 / 45 and cool wait 30000 ticks.
`default_nettype none

module over_temperature_guard_core #(
  parameter int FILTER_LIMIT = otg_pkg::FILTER_LIMIT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire otg_pkg::temp_t       in_temperature,
  input  wire otg_pkg::tick_t       in_now_tick,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_charge_enable,
  output logic                      out_shutdown_request,
  output logic                      out_overheated,
  output otg_pkg::event_cnt_t       out_overheat_events,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire otg_pkg::cfg_idx_t    cfg_index,
  input  wire otg_pkg::cfg_data_t   cfg_wdata
);
  import otg_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  temp_t       s1_temp_r;
  tick_t       s1_tick_r;
  logic        out_valid_r, out_valid_nxt;
  otg_result_t out_r;

  logic        in_take;
  logic        advance;
  logic        step_en;
  otg_cfg_t    cfg;
  otg_result_t result;

  assign advance  = !out_valid_r || !out_stall;
  assign step_en  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  otg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_wdata),
    .cfg     (cfg)
  );

  otg_state #(
    .FILTER_LIMIT (FILTER_LIMIT)
  ) u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (step_en),
    .temperature (s1_temp_r),
    .now_tick    (s1_tick_r),
    .cfg         (cfg),
    .result      (result)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_temp_r <= in_temperature;
      s1_tick_r <= in_now_tick;
    end
    if (step_en) begin
      out_r <= result;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_charge_enable    = out_r.charge_enable;
  assign out_shutdown_request = out_r.shutdown_request;
  assign out_overheated       = out_r.overheated;
  assign out_overheat_events  = out_r.overheat_events;

endmodule

`default_nettype wire

// ----- rtl/core/otg_checker.sv -----
`default_nettype none

module otg_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic                 out_charge_enable,
  input wire logic                 out_shutdown_request,
  input wire logic                 out_overheated,
  input wire otg_pkg::event_cnt_t  out_overheat_events
);
  import otg_pkg::*;

  event_cnt_t last_events_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_events_r <= '0;
    end else if (out_valid && !out_stall) begin
      last_events_r <= out_overheat_events;
    end
  end

  a_shutdown_needs_overheat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shutdown_request |-> out_overheated)
    else $error("shutdown requested without overheat");

  a_charge_vs_overheat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_charge_enable != out_overheated)
    else $error("charge drive and overheat flag disagree");

  a_events_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_overheat_events >= last_events_r)
    else $error("overheat event count went down");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_overheat_events)
      && $stable(out_overheated) && $stable(out_shutdown_request))
    else $error("stalled result changed");

endmodule

bind over_temperature_guard_core otg_checker u_otg_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_charge_enable    (out_charge_enable),
  .out_shutdown_request (out_shutdown_request),
  .out_overheated       (out_overheated),
  .out_overheat_events  (out_overheat_events)
);

`default_nettype wire
